@@ hw/rtl/clwmf_pkg.sv @@
// Shared constants, types and helpers of the clipped window median filter.
// Used by every module of the block but clwmf_ram; depends on nothing.
package clwmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WIN_MAX     = MAX_KERNEL * MAX_KERNEL;
    localparam int WCNT_W      = $clog2(WIN_MAX + 1);
    localparam int SIDX_W      = $clog2(WIN_MAX);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = 16;
    localparam int KER_W       = 3;
    localparam int OFF_W       = 2;
    localparam int GAP_W       = ADDR_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_KERNEL_WIDTH  = 2'd2,
        CFG_KERNEL_HEIGHT = 2'd3
    } t_cfg_idx;

    // geometry after clamping to the legal range
    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic [KER_W-1:0] kw;
        logic [KER_W-1:0] kh;
    } t_cfg;

    // one output pixel handed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] optr;
        logic [OFF_W-1:0]  up;
        logic [OFF_W-1:0]  left;
        logic [KER_W-1:0]  nr;
        logic [KER_W-1:0]  nc;
        logic              last;
    } t_job;

    typedef struct packed {
        logic push;
        logic in_done;
    } t_front_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_READ,
        BK_WAIT,
        BK_EMIT
    } t_back_state;

    // circular store address plus a step of at most one row
    function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [WID_W-1:0] step);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + (ADDR_W+1)'(step);
        if (s >= (ADDR_W+1)'(STORE_DEPTH)) begin
            s = s - (ADDR_W+1)'(STORE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/clwmf_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module clwmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/clwmf_fifo.sv @@
// Short job queue between the front and the back of the median filter.
// Depends on clwmf_pkg.
module clwmf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clwmf_pkg::t_job i_job,
    input  logic            i_pop,
    output clwmf_pkg::t_job o_head,
    output logic            o_full,
    output logic            o_empty
);
    import clwmf_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

@@ hw/rtl/clwmf_front.sv @@
// Front end: accepts words, writes samples to the line store, tracks frame
// positions and queues one job per output pixel. Depends on clwmf_pkg.
module clwmf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  clwmf_pkg::t_cfg                     i_cfg,
    input  logic                                i_restart,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [clwmf_pkg::SAMPLE_BITS-1:0]   i_pixel,
    input  logic                                i_q_full,
    output clwmf_pkg::t_front_stat              o_stat,
    output clwmf_pkg::t_job                     o_job,
    output logic                                o_we,
    output logic [clwmf_pkg::ADDR_W-1:0]        o_waddr,
    output logic [clwmf_pkg::SAMPLE_BITS-1:0]   o_wdata
);
    import clwmf_pkg::*;

    logic [ROW_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic              r_in_done, n_in_done;
    logic [ADDR_W-1:0] r_wptr, n_wptr, r_optr, n_optr;
    logic [GAP_W-1:0]  r_gap, n_gap;

    logic              w_acc, w_sample, w_rdy, w_last;
    logic [KER_W-1:0]  w_khm1, w_kwm1, w_dy3, w_dx3;
    logic [OFF_W-1:0]  w_wy, w_wx, w_dy, w_dx, w_dxc, w_down, w_right;
    logic [WID_W-1:0]  w_wm1, w_cols_right;
    logic [ROW_W-1:0]  w_hm1, w_rows_below;
    logic [GAP_W-1:0]  w_wide, w_lag;

    assign o_ready  = !i_q_full;
    assign w_acc    = i_valid && !i_q_full;
    assign w_sample = !i_action && !r_in_done;

    // window half sizes
    assign w_khm1 = i_cfg.kh - 1'b1;
    assign w_kwm1 = i_cfg.kw - 1'b1;
    assign w_wy   = w_khm1[2:1];
    assign w_wx   = w_kwm1[2:1];
    assign w_dy3  = w_khm1 - {1'b0, w_wy};
    assign w_dx3  = w_kwm1 - {1'b0, w_wx};
    assign w_dy   = w_dy3[OFF_W-1:0];
    assign w_dx   = w_dx3[OFF_W-1:0];
    assign w_wm1  = i_cfg.width - 1'b1;
    assign w_hm1  = i_cfg.height - 1'b1;

    // output lag behind input, in samples
    assign w_wide = GAP_W'(i_cfg.width);
    assign w_dxc  = (WID_W'(w_dx) < w_wm1) ? w_dx : w_wm1[OFF_W-1:0];
    assign w_lag  = (w_dy[1] ? (w_wide << 1) : '0) + (w_dy[0] ? w_wide : '0)
                  + GAP_W'(w_dxc);

    assign w_rdy  = w_sample ? (r_gap >= w_lag) : r_in_done;
    assign w_last = (r_out_row == w_hm1) && (WID_W'(r_out_col) == w_wm1);

    // clipped window of the next output pixel
    assign w_rows_below = w_hm1 - r_out_row;
    assign w_cols_right = w_wm1 - WID_W'(r_out_col);
    assign w_down  = (w_rows_below >= ROW_W'(w_dy)) ? w_dy : w_rows_below[OFF_W-1:0];
    assign w_right = (w_cols_right >= WID_W'(w_dx)) ? w_dx : w_cols_right[OFF_W-1:0];

    always_comb begin
        o_job.optr = r_optr;
        o_job.up   = (r_out_row >= ROW_W'(w_wy)) ? w_wy : r_out_row[OFF_W-1:0];
        o_job.left = (r_out_col >= COL_W'(w_wx)) ? w_wx : r_out_col[OFF_W-1:0];
        o_job.nr   = KER_W'(o_job.up) + KER_W'(w_down) + 1'b1;
        o_job.nc   = KER_W'(o_job.left) + KER_W'(w_right) + 1'b1;
        o_job.last = w_last;
    end

    assign o_stat.push    = w_acc && w_rdy;
    assign o_stat.in_done = r_in_done;
    assign o_we    = w_acc && w_sample;
    assign o_waddr = r_wptr;
    assign o_wdata = i_pixel;

    // position bookkeeping
    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_in_done = r_in_done;
        n_wptr    = r_wptr;
        n_optr    = r_optr;
        n_gap     = r_gap;
        if (i_restart || (w_acc && w_rdy && w_last)) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
            n_in_done = 1'b0;
            n_wptr    = '0;
            n_optr    = '0;
            n_gap     = '0;
            if (!i_restart) begin
                // next frame goes on past this one so pending windows stay intact
                n_wptr = addr_add(r_optr, WID_W'(1));
                n_optr = addr_add(r_optr, WID_W'(1));
            end
        end else if (w_acc) begin
            if (w_sample) begin
                n_wptr = addr_add(r_wptr, WID_W'(1));
                if (WID_W'(r_in_col) == w_wm1) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                    if (r_in_row == w_hm1) begin
                        n_in_done = 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
            if (w_rdy) begin
                n_optr = addr_add(r_optr, WID_W'(1));
                if (WID_W'(r_out_col) == w_wm1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
            n_gap = r_gap + GAP_W'(w_sample) - GAP_W'(w_rdy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_in_done <= 1'b0;
            r_wptr    <= '0;
            r_optr    <= '0;
            r_gap     <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_in_done <= n_in_done;
            r_wptr    <= n_wptr;
            r_optr    <= n_optr;
            r_gap     <= n_gap;
        end
    end
endmodule

@@ hw/rtl/clwmf_back.sv @@
// Back end: walks the clipped window through the line store read port,
// insertion-sorts the samples and presents the median word. Depends on clwmf_pkg.
module clwmf_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [clwmf_pkg::WID_W-1:0]         i_width,
    input  clwmf_pkg::t_job                     i_head,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_re,
    output logic [clwmf_pkg::ADDR_W-1:0]        o_raddr,
    input  logic [clwmf_pkg::SAMPLE_BITS-1:0]   i_rdata,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [clwmf_pkg::SAMPLE_BITS-1:0]   o_median,
    output logic                                o_last
);
    import clwmf_pkg::*;

    t_back_state            r_state, n_state;
    t_job                   r_job;
    logic [ADDR_W-1:0]      r_addr, n_addr, r_row_addr, n_row_addr;
    logic [KER_W-1:0]       r_r, n_r, r_c, n_c;
    logic                   r_rd_valid;
    logic [WCNT_W-1:0]      r_cnt;
    logic [SAMPLE_BITS-1:0] r_sort [WIN_MAX];
    logic [SAMPLE_BITS-1:0] n_sort [WIN_MAX];
    logic [WIN_MAX-1:0]     w_gt;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_med;
    logic                   r_out_last;
    logic                   w_load, w_setup, w_read;
    logic [ADDR_W:0]        w_upw, w_start;
    logic [SIDX_W-1:0]      w_mid;

    assign o_valid  = r_out_valid;
    assign o_median = r_out_med;
    assign o_last   = r_out_last;
    assign o_raddr  = r_addr;
    assign o_re     = w_read;

    // first window address: center minus rows above and columns left
    assign w_upw   = (r_job.up[1] ? ((ADDR_W+1)'(i_width) << 1) : '0)
                   + (r_job.up[0] ? (ADDR_W+1)'(i_width) : '0);
    always_comb begin
        w_start = {1'b0, r_job.optr} - w_upw - (ADDR_W+1)'(r_job.left);
        if (w_start[ADDR_W]) begin
            w_start = w_start + (ADDR_W+1)'(STORE_DEPTH);
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_row_addr = r_row_addr;
        n_r        = r_r;
        n_c        = r_c;
        o_pop      = 1'b0;
        w_load     = 1'b0;
        w_setup    = 1'b0;
        w_read     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_SETUP;
                end
            end
            BK_SETUP: begin
                w_setup    = 1'b1;
                n_addr     = w_start[ADDR_W-1:0];
                n_row_addr = w_start[ADDR_W-1:0];
                n_r        = '0;
                n_c        = '0;
                n_state    = BK_READ;
            end
            BK_READ: begin
                w_read = 1'b1;
                if (r_c == r_job.nc - 1'b1) begin
                    n_c = '0;
                    if (r_r == r_job.nr - 1'b1) begin
                        n_state = BK_WAIT;
                    end else begin
                        n_r        = r_r + 1'b1;
                        n_row_addr = addr_add(r_row_addr, i_width);
                        n_addr     = addr_add(r_row_addr, i_width);
                    end
                end else begin
                    n_c    = r_c + 1'b1;
                    n_addr = addr_add(r_addr, WID_W'(1));
                end
            end
            BK_WAIT: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // insertion of the arriving sample into the sorted row
    always_comb begin
        for (int i = 0; i < WIN_MAX; i++) begin
            w_gt[i] = (WCNT_W'(i) < r_cnt) && (r_sort[i] > i_rdata);
        end
        n_sort[0] = (w_gt[0] || (r_cnt == '0)) ? i_rdata : r_sort[0];
        for (int i = 1; i < WIN_MAX; i++) begin
            if (w_gt[i-1]) begin
                n_sort[i] = r_sort[i-1];
            end else if (w_gt[i] || (WCNT_W'(i) == r_cnt)) begin
                n_sort[i] = i_rdata;
            end else begin
                n_sort[i] = r_sort[i];
            end
        end
    end

    assign w_mid = SIDX_W'(r_cnt >> 1);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (r_rd_valid) begin
            for (int i = 0; i < WIN_MAX; i++) begin
                r_sort[i] <= n_sort[i];
            end
        end
        if (w_load) begin
            r_out_med  <= r_sort[w_mid];
            r_out_last <= r_job.last;
        end
        r_addr     <= n_addr;
        r_row_addr <= n_row_addr;
        r_r        <= n_r;
        r_c        <= n_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rd_valid  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_read;
            if (w_setup) begin
                r_cnt <= '0;
            end else if (r_rd_valid) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

@@ hw/rtl/clipped_window_median_filter_unit.sv @@
// Clipped window median filter: raster stream in, per-pixel window medians out.
// Depends on clwmf_pkg, clwmf_ram, clwmf_fifo, clwmf_front and clwmf_back.
//
// Words are taken one per cycle while the four-entry job queue has room; a
// word whose pixel has its window complete queues one job. The back end
// fetches the nr x nc clipped window (at most 7x7) one sample per cycle
// through the single read port of the line store, and takes the next job
// only once the median of the last one is in its output register. Results
// trail the input by dy*W + min(dx, W-1) samples; drain words (tuser = 1)
// flush the rest after the frame. The line store holds no reset contents
// and needs no clearing pass. Any configuration write restarts the frame.
module clipped_window_median_filter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [clwmf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [clwmf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [15:0]                          s_axis_tdata,  // pixel_value
    input  logic                                 s_axis_tuser,  // action
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // median_value
    output logic                                 m_axis_tlast   // frame_last
);
    import clwmf_pkg::*;

    logic [WID_W-1:0]       r_width;
    logic [ROW_W-1:0]       r_height;
    logic [KER_W-1:0]       r_kw, r_kh;
    t_cfg                   w_cfg;
    t_front_stat            w_stat;
    t_job                   w_job, w_head;
    logic                   w_q_full, w_q_empty, w_pop;
    logic                   w_we, w_re;
    logic [ADDR_W-1:0]      w_waddr, w_raddr;
    logic [SAMPLE_BITS-1:0] w_wdata, w_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(640);
            r_height <= ROW_W'(480);
            r_kw     <= KER_W'(3);
            r_kh     <= KER_W'(3);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[WID_W-1:0];
                CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[ROW_W-1:0];
                CFG_KERNEL_WIDTH:  r_kw     <= i_cfg_data[KER_W-1:0];
                CFG_KERNEL_HEIGHT: r_kh     <= i_cfg_data[KER_W-1:0];
                default:           r_kh     <= r_kh;
            endcase
        end
    end

    // clamp geometry to the legal range
    always_comb begin
        w_cfg.width = r_width;
        if (r_width == '0) begin
            w_cfg.width = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_cfg.width = WID_W'(MAX_WIDTH);
        end
        w_cfg.height = (r_height == '0) ? ROW_W'(1) : r_height;
        w_cfg.kw     = (r_kw == '0) ? KER_W'(1) : r_kw;
        w_cfg.kh     = (r_kh == '0) ? KER_W'(1) : r_kh;
    end

    clwmf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_restart (i_cfg_we),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser),
        .i_pixel   (s_axis_tdata),
        .i_q_full  (w_q_full),
        .o_stat    (w_stat),
        .o_job     (w_job),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata)
    );

    clwmf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_stat.push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    clwmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    clwmf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (w_cfg.width),
        .i_head   (w_head),
        .i_empty  (w_q_empty),
        .o_pop    (w_pop),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_median (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

    // jobs only enter a queue with room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.push |-> !w_q_full)
        else $error("job pushed into full queue");

    // back end only takes a job that exists
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("job popped from empty queue");

    // the frame's last job restarts the front end
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.push && w_job.last) |=> !w_stat.in_done)
        else $error("front not restarted after last pixel");
endmodule

@@ verif/tb_clipped_window_median_filter_unit.sv @@
// Self-checking testbench of the clipped window median filter unit.
// Depends on clwmf_pkg and clipped_window_median_filter_unit from hw/rtl.
module tb_clipped_window_median_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import clwmf_pkg::*;

    typedef struct {
        logic [15:0] median;
        logic        last;
    } t_pixel_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // pixel_value
    logic                  s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // median_value
    logic                  m_axis_tlast;   // frame_last

    clipped_window_median_filter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state: registers, line store and raster positions
    logic [10:0]  geo_w;
    logic [15:0]  geo_h;
    logic [2:0]   geo_kw;
    logic [2:0]   geo_kh;
    logic [15:0]  line_mem [STORE_DEPTH];
    int unsigned  in_r, in_c, out_r, out_c;
    bit           input_full;

    t_pixel_out   median_q[$];
    int           errors;
    int           words_sent;
    bit           idle_on;
    int           hold_cycles;
    int           rx_gap;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("FAIL clipped_window_median_filter_unit");
        $finish;
    end

    function automatic int unsigned eff_w();
        return (geo_w == 0) ? 1 : (geo_w > MAX_WIDTH) ? MAX_WIDTH : geo_w;
    endfunction

    function automatic int unsigned eff_h();
        return (geo_h == 0) ? 1 : geo_h;
    endfunction

    function automatic void restart_raster();
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
        input_full = 1'b0;
    endfunction

    // advance the predictor by one accepted word, queue the median it yields
    function automatic void predict_median(bit drain, logic [15:0] px);
        int unsigned w, h, kw, kh, dx, dy, lag, n, p, wy, wx, r0, c0, r1, c1, cnt;
        int          j;
        bit          rdy;
        logic [15:0] win [WIN_MAX];
        logic [15:0] v;
        t_pixel_out  e;
        w = eff_w();
        h = eff_h();
        kw = (geo_kw == 0) ? 1 : geo_kw;
        kh = (geo_kh == 0) ? 1 : geo_kh;
        dx = kw - 1 - (kw - 1) / 2;
        dy = kh - 1 - (kh - 1) / 2;
        lag = dy * w + ((dx < w - 1) ? dx : w - 1);
        if (!drain && !input_full) begin
            n = in_r * w + in_c;
            p = out_r * w + out_c;
            line_mem[n % STORE_DEPTH] = px;
            in_c++;
            if (in_c >= w) begin
                in_c = 0;
                in_r++;
                if (in_r >= h) input_full = 1'b1;
            end
            rdy = (p + lag <= n);
        end else begin
            rdy = input_full;
        end
        if (!rdy) return;
        // clipped window, then insertion sort
        wy = (kh - 1) / 2;
        wx = (kw - 1) / 2;
        r0 = (out_r >= wy) ? out_r - wy : 0;
        c0 = (out_c >= wx) ? out_c - wx : 0;
        r1 = out_r + (kh - 1 - wy);
        c1 = out_c + (kw - 1 - wx);
        if (r1 > h - 1) r1 = h - 1;
        if (c1 > w - 1) c1 = w - 1;
        cnt = 0;
        for (int unsigned rr = r0; rr <= r1; rr++) begin
            for (int unsigned cc = c0; cc <= c1; cc++) begin
                win[cnt] = line_mem[(rr * w + cc) % STORE_DEPTH];
                cnt++;
            end
        end
        for (int i = 1; i < cnt; i++) begin
            v = win[i];
            j = i;
            while (j > 0 && win[j-1] > v) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = v;
        end
        e.median = win[cnt / 2];
        e.last = (out_r == h - 1) && (out_c == w - 1);
        median_q.push_back(e);
        if (e.last) begin
            restart_raster();
        end else begin
            out_c++;
            if (out_c >= w) begin
                out_c = 0;
                out_r++;
            end
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_pixel_out e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (median_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: median %h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                e = median_q.pop_front();
                if (e.median !== m_axis_tdata || e.last !== m_axis_tlast) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected median %h last %b, got median %h last %b",
                                 e.median, e.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // receiver ready: long hold-off, random stall bursts or ready
    initial begin
        m_axis_tready = 1'b0;
        rx_gap = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end else if (rx_gap > 0) begin
                m_axis_tready = 1'b0;
                rx_gap--;
            end else begin
                m_axis_tready = 1'b1;
                if (idle_on && $urandom_range(0, 15) == 0) rx_gap = $urandom_range(1, 12);
            end
        end
    end

    // send one word, predicting at the accepting edge
    task automatic send_word(bit drain, logic [15:0] px);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = px;
        s_axis_tuser = drain;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_median(drain, px);
        words_sent++;
    endtask

    // sender pauses until every expected median is out and the block settles
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:   geo_w = val[10:0];
            CFG_IMAGE_HEIGHT:  geo_h = val;
            CFG_KERNEL_WIDTH:  geo_kw = val[2:0];
            CFG_KERNEL_HEIGHT: geo_kh = val[2:0];
            default: ;
        endcase
        restart_raster();
    endtask

    task automatic set_geometry(int w, int h, int kw, int kh);
        wait_drained();
        cfg_write(CFG_IMAGE_WIDTH, 16'(w));
        cfg_write(CFG_IMAGE_HEIGHT, 16'(h));
        cfg_write(CFG_KERNEL_WIDTH, 16'(kw));
        cfg_write(CFG_KERNEL_HEIGHT, 16'(kh));
    endtask

    // one whole frame of random samples, then drains; noise adds stray words
    task automatic send_frame(int noise_pct);
        int unsigned total;
        total = eff_w() * eff_h();
        for (int unsigned k = 0; k < total; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(1'b1, 16'($urandom_range(0, 65535)));
            send_word(1'b0, 16'($urandom_range(0, 65535)));
        end
        while (input_full) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(1'b0, 16'($urandom_range(0, 65535)));
            else
                send_word(1'b1, 16'($urandom_range(0, 65535)));
        end
    endtask

    // extremes of the samples, drain before end, sample after end
    task automatic test_directed();
        set_geometry(3, 2, 3, 3);
        send_word(1'b0, 16'h0000);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h0001);
        send_word(1'b0, 16'hFFFE);
        send_word(1'b0, 16'h1234);
        while (input_full) send_word(1'b1, 16'h0000);
        // zero geometry acts as a one pixel frame
        set_geometry(0, 0, 0, 0);
        send_word(1'b0, 16'hFFFF);
        // even kernels give the upper median
        set_geometry(2, 3, 2, 4);
        send_frame(0);
        // kernels wider than the image
        set_geometry(1, 3, 7, 7);
        send_frame(0);
    endtask

    // write during a frame restarts it; tallest frame setting
    task automatic test_restart();
        set_geometry(5, 65535, 3, 5);
        repeat (12) send_word(1'b0, 16'($urandom_range(0, 65535)));
        wait_drained();
        cfg_write(CFG_IMAGE_HEIGHT, 16'd4);
        send_frame(10);
        wait_drained();
        cfg_write(CFG_KERNEL_WIDTH, 16'd5);
        send_frame(0);
    endtask

    // long receiver hold-off while the sender keeps offering words
    task automatic test_backpressure();
        set_geometry(9, 6, 7, 7);
        hold_cycles = 600;
        send_frame(0);
    endtask

    // widest row: a width above the limit acts as the limit
    task automatic test_wide_row();
        set_geometry(2047, 1, 7, 1);
        send_frame(0);
    endtask

    task automatic test_random_frames();
        int stop_at;
        stop_at = words_sent + 250;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                set_geometry($urandom_range(0, 40), $urandom_range(0, 4),
                             $urandom_range(0, 7), $urandom_range(0, 7));
            else
                set_geometry($urandom_range(1, 16), $urandom_range(1, 10),
                             $urandom_range(0, 7), $urandom_range(0, 7));
            send_frame($urandom_range(0, 3) == 0 ? 10 : 0);
        end
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        set_geometry(12, 6, 3, 3);
        send_frame(0);
        set_geometry(7, 5, 1, 1);
        send_frame(0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        geo_w = 640;
        geo_h = 480;
        geo_kw = 3;
        geo_kh = 3;
        restart_raster();
        errors = 0;
        words_sent = 0;
        idle_on = 1'b1;
        hold_cycles = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_restart();
        test_backpressure();
        test_wide_row();
        test_random_frames();
        test_full_rate();

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && median_q.size() == 0) begin
            $display("PASS clipped_window_median_filter_unit");
        end else begin
            $display("FAIL clipped_window_median_filter_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/clwmf_pkg.sv
hw/rtl/clwmf_ram.sv
hw/rtl/clwmf_fifo.sv
hw/rtl/clwmf_front.sv
hw/rtl/clwmf_back.sv
hw/rtl/clipped_window_median_filter_unit.sv
verif/tb_clipped_window_median_filter_unit.sv
